/* rtl/core/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, constants and helpers for the perspective projection core.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 8;

    localparam int CW  = 16;   // coordinate / matrix entry width
    localparam int DW  = 17;   // camera-relative coordinate
    localparam int PW  = 33;   // one matrix product
    localparam int RW  = 35;   // rotated coordinate
    localparam int NW  = 52;   // rotated coordinate times focal length
    localparam int QW  = 18;   // quotient magnitude bits
    localparam int RMW = 53;   // divider remainder width

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROW2   = 3'd2;
    localparam logic [2:0] REG_CAM    = 3'd3;
    localparam logic [2:0] REG_FOCAL  = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [47:0] row0;
        logic [47:0] row1;
        logic [47:0] row2;
        logic [47:0] cam;
        logic [15:0] focal;
        logic [31:0] offset;
    } cfg_t;

    typedef struct packed {
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [RW-1:0] rz;
    } rot_t;

    typedef struct packed {
        logic          zero;
        logic          negx;
        logic          negy;
        logic          bigx;
        logic          bigy;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
    } dres_t;

    function automatic logic signed [CW-1:0] lane16(input logic [47:0] word,
                                                   input int unsigned idx);
        lane16 = $signed(word[idx*CW +: CW]);
    endfunction

endpackage

/* rtl/core/perspective_point_projection_core.sv */
// Pipeline from accepted point to result: transform, focal multiply,
// divider setup, divider steps, output stage.
// Throughput: one point per cycle unless stalled; the 18 divider step stages
// resolve one quotient bit each. A stalled result freezes the whole pipeline.
// Reset: valid bits clear; registers return to identity matrix, zero camera
// and offset, focal length 1.0.
// ----------------------------------------------------------------------------
// perspective_point_projection_core
// Pinhole camera projection of Q8.8 points to saturated screen coordinates.
// ----------------------------------------------------------------------------
module perspective_point_projection_core #(
    parameter int COORD_FRAC_BITS = ppp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppp_pkg::ADDR_W-1:0]      paddr,
    input  logic [ppp_pkg::DATA_W-1:0]      pwdata,
    output logic [ppp_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            pt_valid,
    output logic                            pt_stall,
    input  logic signed [ppp_pkg::CW-1:0]   point_x,
    input  logic signed [ppp_pkg::CW-1:0]   point_y,
    input  logic signed [ppp_pkg::CW-1:0]   point_z,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic signed [ppp_pkg::CW-1:0]   screen_x,
    output logic signed [ppp_pkg::CW-1:0]   screen_y,
    output logic [1:0]                      status
);
    import ppp_pkg::*;

    cfg_t                 cfg;
    rot_t                 rot;
    dres_t                dres;
    logic                 en;
    logic                 xf_valid, dv_valid;
    logic                 m_valid_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [RW-1:0] rz_reg;

    assign en       = !(res_valid && res_stall);
    assign pt_stall = !en;

    ppp_cfg #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pt_valid),
        .px        (point_x),
        .py        (point_y),
        .pz        (point_z),
        .cfg       (cfg),
        .out_valid (xf_valid),
        .rot       (rot)
    );

    // focal length scaling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= xf_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= NW'(rot.rx) * $signed(NW'({1'b0, cfg.focal}));
            ny_reg <= NW'(rot.ry) * $signed(NW'({1'b0, cfg.focal}));
            rz_reg <= rot.rz;
        end
    end

    ppp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .nx        (nx_reg),
        .ny        (ny_reg),
        .den       (rz_reg),
        .out_valid (dv_valid),
        .res       (dres)
    );

    ppp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .res       (dres),
        .offset    (cfg.offset),
        .out_valid (res_valid),
        .sx        (screen_x),
        .sy        (screen_y),
        .st        (status)
    );

endmodule

/* rtl/core/ppp_cfg.sv */
// ----------------------------------------------------------------------------
// ppp_cfg
// APB-style register file holding matrix, camera, focal length and offset.
// ----------------------------------------------------------------------------
module ppp_cfg #(
    parameter int COORD_FRAC_BITS = ppp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppp_pkg::DATA_W-1:0]  pwdata,
    output logic [ppp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ppp_pkg::cfg_t               cfg
);
    import ppp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_ROW0:   cfg_next.row0   = pwdata[47:0];
                REG_ROW1:   cfg_next.row1   = pwdata[47:0];
                REG_ROW2:   cfg_next.row2   = pwdata[47:0];
                REG_CAM:    cfg_next.cam    = pwdata[47:0];
                REG_FOCAL:  cfg_next.focal  = pwdata[15:0];
                REG_OFFSET: cfg_next.offset = pwdata[31:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row0   <= 48'h0000_0000_4000;
            cfg_reg.row1   <= 48'h0000_4000_0000;
            cfg_reg.row2   <= 48'h4000_0000_0000;
            cfg_reg.cam    <= '0;
            cfg_reg.focal  <= 16'(1) << COORD_FRAC_BITS;
            cfg_reg.offset <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW0:   prdata = {16'd0, cfg_reg.row0};
            REG_ROW1:   prdata = {16'd0, cfg_reg.row1};
            REG_ROW2:   prdata = {16'd0, cfg_reg.row2};
            REG_CAM:    prdata = {16'd0, cfg_reg.cam};
            REG_FOCAL:  prdata = {48'd0, cfg_reg.focal};
            REG_OFFSET: prdata = {32'd0, cfg_reg.offset};
            default:    prdata = '0;
        endcase
    end

endmodule

/* rtl/core/ppp_xform.sv */
// ----------------------------------------------------------------------------
// ppp_xform
// Camera translate and 3x3 rotation: subtract, multiply, sum (three stages).
// ----------------------------------------------------------------------------
module ppp_xform (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [ppp_pkg::CW-1:0]   px,
    input  logic signed [ppp_pkg::CW-1:0]   py,
    input  logic signed [ppp_pkg::CW-1:0]   pz,
    input  ppp_pkg::cfg_t                   cfg,
    output logic                            out_valid,
    output ppp_pkg::rot_t                   rot
);
    import ppp_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [DW-1:0] d_reg    [3];
    logic signed [DW-1:0] d_next   [3];
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [CW-1:0] pin      [3];
    logic [47:0]          rows     [3];
    rot_t                 rot_reg;
    rot_t                 rot_next;

    assign pin[0]  = px;
    assign pin[1]  = py;
    assign pin[2]  = pz;
    assign rows[0] = cfg.row0;
    assign rows[1] = cfg.row1;
    assign rows[2] = cfg.row2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = DW'(pin[i]) - DW'(lane16(cfg.cam, i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= d_next[i];
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PW'(lane16(rows[r], c)) * PW'(d_reg[c]);
                end
            end
            rot_reg <= rot_next;
        end
    end

    always_comb
    begin
        rot_next.rx = RW'(prod_reg[0][0]) + RW'(prod_reg[0][1]) + RW'(prod_reg[0][2]);
        rot_next.ry = RW'(prod_reg[1][0]) + RW'(prod_reg[1][1]) + RW'(prod_reg[1][2]);
        rot_next.rz = RW'(prod_reg[2][0]) + RW'(prod_reg[2][1]) + RW'(prod_reg[2][2]);
    end

    assign out_valid = v3_reg;
    assign rot       = rot_reg;

endmodule

/* rtl/core/ppp_div.sv */
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing one divisor. Quotients of 2^QW or more are flagged as big.
// ----------------------------------------------------------------------------
module ppp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [ppp_pkg::NW-1:0]   nx,
    input  logic signed [ppp_pkg::NW-1:0]   ny,
    input  logic signed [ppp_pkg::RW-1:0]   den,
    output logic                            out_valid,
    output ppp_pkg::dres_t                  res
);
    import ppp_pkg::*;

    logic                 v_reg    [QW+1];
    logic [RMW-1:0]       remx_reg [QW+1];
    logic [RMW-1:0]       remy_reg [QW+1];
    logic [RW-1:0]        dv_reg   [QW+1];
    logic [QW-1:0]        qx_reg   [QW+1];
    logic [QW-1:0]        qy_reg   [QW+1];
    logic                 negx_reg [QW+1];
    logic                 negy_reg [QW+1];
    logic                 bigx_reg [QW+1];
    logic                 bigy_reg [QW+1];
    logic                 zero_reg [QW+1];

    logic [NW-1:0]  ax, ay;
    logic [RW-1:0]  ad;
    logic [RMW-1:0] lim;

    assign ax  = nx[NW-1] ? NW'(-nx) : NW'(nx);
    assign ay  = ny[NW-1] ? NW'(-ny) : NW'(ny);
    assign ad  = den[RW-1] ? RW'(-den) : RW'(den);
    assign lim = RMW'(ad) << QW;

    // prep stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg[0] <= RMW'(ax);
            remy_reg[0] <= RMW'(ay);
            dv_reg[0]   <= ad;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            negx_reg[0] <= nx[NW-1] ^ den[RW-1];
            negy_reg[0] <= ny[NW-1] ^ den[RW-1];
            bigx_reg[0] <= RMW'(ax) >= lim;
            bigy_reg[0] <= RMW'(ay) >= lim;
            zero_reg[0] <= (den == '0);
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int SH = QW - 1 - k;
        logic [RMW-1:0] dsh;
        logic           gex, gey;

        assign dsh = RMW'(dv_reg[k]) << SH;
        assign gex = remx_reg[k] >= dsh;
        assign gey = remy_reg[k] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[k+1] <= gex ? remx_reg[k] - dsh : remx_reg[k];
                remy_reg[k+1] <= gey ? remy_reg[k] - dsh : remy_reg[k];
                qx_reg[k+1]   <= qx_reg[k] | (QW'(gex) << SH);
                qy_reg[k+1]   <= qy_reg[k] | (QW'(gey) << SH);
                dv_reg[k+1]   <= dv_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                bigx_reg[k+1] <= bigx_reg[k];
                bigy_reg[k+1] <= bigy_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign res.zero  = zero_reg[QW];
    assign res.negx  = negx_reg[QW];
    assign res.negy  = negy_reg[QW];
    assign res.bigx  = bigx_reg[QW];
    assign res.bigy  = bigy_reg[QW];
    assign res.qx    = qx_reg[QW];
    assign res.qy    = qy_reg[QW];

endmodule

/* rtl/core/ppp_out.sv */
// ----------------------------------------------------------------------------
// ppp_out
// Output stage: apply sign and screen offset, saturate, form status.
// ----------------------------------------------------------------------------
module ppp_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  ppp_pkg::dres_t                  res,
    input  logic [31:0]                     offset,
    output logic                            out_valid,
    output logic signed [ppp_pkg::CW-1:0]   sx,
    output logic signed [ppp_pkg::CW-1:0]   sy,
    output logic [1:0]                      st
);
    import ppp_pkg::*;

    localparam int SW = QW + 3;

    logic                 v_reg;
    logic signed [CW-1:0] sx_reg, sy_reg;
    logic [1:0]           st_reg;
    logic signed [CW-1:0] sx_next, sy_next;
    logic [1:0]           st_next;
    logic                 satx, saty;

    function automatic logic signed [SW-1:0] place(input logic signed [CW-1:0] off,
                                                   input logic [QW-1:0] q,
                                                   input logic big,
                                                   input logic neg);
        logic [QW-1:0] qm;
        qm = big ? '1 : q;
        // screen = off - (n/rz); neg means n/rz < 0
        place = neg ? SW'(off) + SW'(qm) : SW'(off) - SW'(qm);
    endfunction

    function automatic logic signed [CW-1:0] clamp(input logic signed [SW-1:0] v,
                                                   output logic sat);
        if (v > SW'(32767))
        begin
            sat   = 1'b1;
            clamp = 16'sh7FFF;
        end
        else if (v < -SW'(32768))
        begin
            sat   = 1'b1;
            clamp = 16'sh8000;
        end
        else
        begin
            sat   = 1'b0;
            clamp = CW'(v);
        end
    endfunction

    always_comb
    begin
        sx_next = clamp(place($signed(offset[15:0]), res.qx, res.bigx, res.negx), satx);
        sy_next = clamp(place($signed(offset[31:16]), res.qy, res.bigy, res.negy), saty);
        st_next = (satx || saty) ? ST_SAT : ST_OK;
        if (res.zero)
        begin
            sx_next = '0;
            sy_next = '0;
            st_next = ST_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = v_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign st        = st_reg;

endmodule

/* dv/ppp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppp_checker
// Watches the configuration port and both point/result channels, predicts
// each projection and compares it field by field with the core's output.
// ----------------------------------------------------------------------------
module ppp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ppp_pkg::ADDR_W-1:0]    paddr,
    input  logic [ppp_pkg::DATA_W-1:0]    pwdata,
    input  logic                          pt_valid,
    input  logic                          pt_stall,
    input  logic signed [15:0]            point_x,
    input  logic signed [15:0]            point_y,
    input  logic signed [15:0]            point_z,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic signed [15:0]            screen_x,
    input  logic signed [15:0]            screen_y,
    input  logic [1:0]                    status,
    output int                            errors,
    output int                            pending,
    output int                            results_seen,
    output int                            sat_seen,
    output int                            zero_seen
);
    import ppp_pkg::*;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [1:0]         st;
    } proj_t;

    cfg_t  cfg;
    proj_t proj_q[$];

    function automatic longint entry(input logic [47:0] w, input int k);
        logic signed [15:0] v;
        v = w[k*16 +: 16];
        return longint'(v);
    endfunction

    function automatic longint sat16(input longint v, inout bit sat);
        if (v > 32767) begin sat = 1; return 32767; end
        if (v < -32768) begin sat = 1; return -32768; end
        return v;
    endfunction

    function automatic proj_t project(input logic signed [15:0] px,
                                      input logic signed [15:0] py,
                                      input logic signed [15:0] pz);
        longint d[3];
        longint rx, ry, rz, f, qx, qy;
        bit     sat;
        proj_t  p;
        sat = 0;
        d[0] = longint'(px) - entry(cfg.cam, 0);
        d[1] = longint'(py) - entry(cfg.cam, 1);
        d[2] = longint'(pz) - entry(cfg.cam, 2);
        rx = entry(cfg.row0, 0) * d[0] + entry(cfg.row0, 1) * d[1] + entry(cfg.row0, 2) * d[2];
        ry = entry(cfg.row1, 0) * d[0] + entry(cfg.row1, 1) * d[1] + entry(cfg.row1, 2) * d[2];
        rz = entry(cfg.row2, 0) * d[0] + entry(cfg.row2, 1) * d[1] + entry(cfg.row2, 2) * d[2];
        if (rz == 0)
        begin
            p.sx = 0;
            p.sy = 0;
            p.st = ST_ZERO;
            return p;
        end
        f  = longint'(cfg.focal);
        // SV division truncates toward zero, matching the divider
        qx = -((rx * f) / rz) + entry({16'd0, cfg.offset}, 0);
        qy = -((ry * f) / rz) + entry({16'd0, cfg.offset}, 1);
        p.sx = 16'(sat16(qx, sat));
        p.sy = 16'(sat16(qy, sat));
        p.st = sat ? ST_SAT : ST_OK;
        return p;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = proj_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.row0   <= 48'd16384;
            cfg.row1   <= 48'd16384 << 16;
            cfg.row2   <= 48'd16384 << 32;
            cfg.cam    <= '0;
            cfg.focal  <= 16'd256;
            cfg.offset <= '0;
            proj_q.delete();
            errors       <= 0;
            results_seen <= 0;
            sat_seen     <= 0;
            zero_seen    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_ROW0:   cfg.row0   <= pwdata[47:0];
                    REG_ROW1:   cfg.row1   <= pwdata[47:0];
                    REG_ROW2:   cfg.row2   <= pwdata[47:0];
                    REG_CAM:    cfg.cam    <= pwdata[47:0];
                    REG_FOCAL:  cfg.focal  <= pwdata[15:0];
                    REG_OFFSET: cfg.offset <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (pt_valid && !pt_stall)
                proj_q.push_back(project(point_x, point_y, point_z));
            if (res_valid && !res_stall)
            begin
                proj_t want;
                results_seen <= results_seen + 1;
                if (status == ST_SAT) sat_seen <= sat_seen + 1;
                if (status == ST_ZERO) zero_seen <= zero_seen + 1;
                if (proj_q.size() == 0)
                    report("unexpected result, status", status, -1);
                else
                begin
                    want = proj_q.pop_front();
                    if (screen_x !== want.sx) report("screen_x", screen_x, want.sx);
                    if (screen_y !== want.sy) report("screen_y", screen_y, want.sy);
                    if (status !== want.st) report("status", status, want.st);
                end
            end
        end
    end
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the projection core: register phases over several camera
// setups, directed corner points, then bursty random points with stalls.
// ----------------------------------------------------------------------------
module tb;
    import ppp_pkg::*;

    localparam int LATENCY  = 24;
    localparam int WD_LIMIT = 2000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic pt_valid = 0;
    logic pt_stall;
    logic signed [15:0] point_x = 0, point_y = 0, point_z = 0;
    logic res_valid;
    logic res_stall = 0;
    logic signed [15:0] screen_x, screen_y;
    logic [1:0] status;

    int errors, pending, results_seen, sat_seen, zero_seen;
    int idle_cycles = 0;
    int stall_mode = 0;
    int points_sent = 0;

    always #10 clk = ~clk;

    perspective_point_projection_core DUT (.*);

    ppp_checker u_checker (.*);

    // receiver stall pattern: phases of never, always-ish, and random stalling
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= (r < 70);
            default: res_stall <= (r < 25);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge clk)
    begin
        if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired with %0d projections outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        pt_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        @(posedge clk);
        while (pt_stall) @(posedge clk);
        @(negedge clk);
        points_sent++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_row();
        logic [47:0] w;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 3))
                0: w[k*16 +: 16] = 16'd0;
                1: w[k*16 +: 16] = 16'h4000;
                2: w[k*16 +: 16] = 16'hc000;
                default: w[k*16 +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic burst_points(input int n);
        int gap;
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    pt_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst--;
            send_point(rand_coord(), rand_coord(), rand_coord());
        end
        pt_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed points with reset config: identity, focal 1.0
        send_point(16'h0100, 16'h0100, 16'h0100);
        send_point(16'h0100, 16'h0100, 16'h0000);        // depth zero
        send_point(16'h7fff, 16'h8000, 16'h0001);        // saturates
        send_point(16'h8000, 16'h7fff, 16'h8000);
        send_point(16'h8000, 16'h8000, 16'h7fff);
        send_point(16'h0000, 16'h0000, 16'hffff);
        send_point(16'hffff, 16'h0001, 16'h0001);
        send_point(16'h0003, 16'hfffd, 16'h0002);        // opposite-sign quotients, divide exactly
        send_point(16'hfffd, 16'h0003, 16'h0002);
        pt_valid <= 1'b0;
        drain();

        // extremes of every register
        reg_write(REG_ROW0, 64'h8000_7fff_8000);
        reg_write(REG_ROW1, 64'h7fff_8000_7fff);
        reg_write(REG_ROW2, 64'hffff_ffff_ffff);
        reg_write(REG_CAM, 64'h7fff_8000_7fff);
        reg_write(REG_FOCAL, 64'hffff);
        reg_write(REG_OFFSET, 64'h7fff_8000);
        send_point(16'h8000, 16'h7fff, 16'h8000);
        send_point(16'h7fff, 16'h8000, 16'h7fff);
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h1234, 16'h5678, 16'h9abc);
        pt_valid <= 1'b0;
        drain();

        reg_write(REG_FOCAL, 64'h0);
        reg_write(REG_OFFSET, 64'h8000_7fff);
        reg_write(REG_ROW2, 64'h0000_0000_0000);  // every point has zero depth
        send_point(16'h1111, 16'h2222, 16'h3333);
        send_point(16'h8000, 16'h8000, 16'h8000);
        pt_valid <= 1'b0;
        drain();

        // random phases; the drain before each rewrite also stalls the sender
        for (int ph = 0; ph < 12; ph++)
        begin
            reg_write(REG_ROW0, 64'(rand_row()));
            reg_write(REG_ROW1, 64'(rand_row()));
            reg_write(REG_ROW2, 64'(rand_row()));
            reg_write(REG_CAM, 64'({$urandom_range(0, 1) ? 16'($urandom) : 16'h0,
                                    16'($urandom), 16'($urandom)}));
            reg_write(REG_FOCAL, $urandom_range(0, 1) ? 64'($urandom_range(0, 2048))
                                                     : 64'(16'($urandom)));
            reg_write(REG_OFFSET, 64'($urandom));
            burst_points(104);
            drain();
        end

        $display("%0d points sent, %0d results checked (%0d saturated, %0d zero depth)",
                 points_sent, results_seen, sat_seen, zero_seen);
        $display("15 register setups incl. extremes, bursty sender and stalling receiver");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
